// ----- src/tve_pkg.sv -----
// Shared types and constants for the touch velocity estimator.
`default_nettype none
package tve_pkg;
	localparam int RING_DEPTH = 16;
	localparam int FRAC_BITS  = 16;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int DELTA_W    = 17;
	localparam int DVD_W      = DELTA_W + FRAC_BITS;
	localparam int CNT_W      = $clog2(DVD_W + 1);

	localparam logic [1:0] CMD_REC   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [15:0] STOP_RST   = 16'd100;
	localparam logic [15:0] WINDOW_RST = 16'd60;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEW,
		ST_WALK,
		ST_DIV,
		ST_FIN_DIV,
		ST_FIN_ZERO
	} tve_state_t;

	typedef struct packed {
		logic wr;
		logic clr;
		logic ld_query;
		logic cap_new;
		logic step;
		logic div_init;
		logic div_step;
		logic out_div;
		logic out_zero;
	} tve_ctl_t;

	typedef struct packed {
		logic few_samples;
		logic age_ge_stop;
		logic age_ge_win;
		logic age_pos;
		logic idx_zero;
		logic win_zero;
		logic div_done;
		logic out_free;
	} tve_sts_t;
endpackage
`default_nettype wire

// ----- src/tve_ctrl.sv -----
// Sequencing state machine for record, clear and query words.
`default_nettype none
module tve_ctrl import tve_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] command,
	input  wire tve_sts_t   sts,
	output tve_ctl_t        ctl,
	output logic            in_stall
);
	tve_state_t state_q, state_nxt;
	logic walk_end;

	assign walk_end = sts.age_ge_win || sts.idx_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && command == CMD_QUERY) begin
					state_nxt = sts.few_samples ? ST_FIN_ZERO : ST_NEW;
				end
			end
			ST_NEW: begin
				if (sts.age_ge_stop || sts.win_zero) begin
					state_nxt = ST_FIN_ZERO;
				end else if (walk_end) begin
					state_nxt = sts.age_pos ? ST_DIV : ST_FIN_ZERO;
				end else begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_nxt = sts.age_pos ? ST_DIV : ST_FIN_ZERO;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nxt = ST_FIN_DIV;
				end
			end
			ST_FIN_DIV, ST_FIN_ZERO: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.wr       = (command == CMD_REC);
					ctl.clr      = (command == CMD_CLEAR);
					ctl.ld_query = (command == CMD_QUERY);
				end
			end
			ST_NEW: begin
				ctl.cap_new = 1'b1;
				if (!sts.age_ge_stop && !sts.win_zero) begin
					ctl.div_init = walk_end && sts.age_pos;
					ctl.step     = !walk_end;
				end
			end
			ST_WALK: begin
				ctl.div_init = walk_end && sts.age_pos;
				ctl.step     = !walk_end;
			end
			ST_DIV:      ctl.div_step = !sts.div_done;
			ST_FIN_DIV:  ctl.out_div  = sts.out_free;
			ST_FIN_ZERO: ctl.out_zero = sts.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/tve_dp.sv -----
// Sample ring, walk registers, two serial dividers and result register.
`default_nettype none
module tve_dp import tve_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tve_ctl_t           ctl,
	output tve_sts_t                sts,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [31:0]        stamp,
	input  wire logic [15:0]        stop_time,
	input  wire logic [15:0]        window_time,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y
);
	logic signed [15:0] mem_x [RING_DEPTH];
	logic signed [15:0] mem_y [RING_DEPTH];
	logic [31:0]        mem_t [RING_DEPTH];

	logic [SLOT_W-1:0] wslot_q, idx_q, rd_slot;
	logic [FILL_W-1:0] filled_q;
	logic [31:0]       now_q;
	logic signed [15:0] new_x_q, new_y_q, rd_x, rd_y;
	logic signed [15:0] new_x, new_y;
	logic signed [31:0] age;
	logic [31:0]       span_q;
	logic [DVD_W-1:0]  dvd_q [2];
	logic [DVD_W-1:0]  rem_q [2];
	logic              neg_q [2];
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic signed [31:0] vel_x_q, vel_y_q;
	logic signed [DELTA_W-1:0] delta [2];
	logic [DVD_W-1:0]  trial [2];
	logic [31:0]       sat [2];

	assign rd_slot = wslot_q - filled_q[SLOT_W-1:0] + idx_q;
	assign rd_x = mem_x[rd_slot];
	assign rd_y = mem_y[rd_slot];
	assign age  = $signed(now_q - mem_t[rd_slot]);

	assign sts.few_samples = filled_q < FILL_W'(2);
	assign sts.age_ge_stop = age >= $signed({16'd0, stop_time});
	assign sts.age_ge_win  = age >= $signed({16'd0, window_time});
	assign sts.age_pos     = age > 32'sd0;
	assign sts.idx_zero    = idx_q == '0;
	assign sts.win_zero    = window_time == '0;
	assign sts.div_done    = cnt_q == '0;
	assign sts.out_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_x[wslot_q] <= pos_x;
			mem_y[wslot_q] <= pos_y;
			mem_t[wslot_q] <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q  <= '0;
			filled_q <= '0;
		end else if (ctl.clr) begin
			wslot_q  <= '0;
			filled_q <= '0;
		end else if (ctl.wr) begin
			wslot_q <= wslot_q + SLOT_W'(1);
			if (filled_q != FILL_W'(RING_DEPTH)) begin
				filled_q <= filled_q + FILL_W'(1);
			end
		end
	end

	// newest sample is on the read port while it is being captured
	assign new_x = ctl.cap_new ? rd_x : new_x_q;
	assign new_y = ctl.cap_new ? rd_y : new_y_q;

	assign delta[0] = DELTA_W'(new_x) - DELTA_W'(rd_x);
	assign delta[1] = DELTA_W'(new_y) - DELTA_W'(rd_y);

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			trial[a] = {rem_q[a][DVD_W-2:0], dvd_q[a][DVD_W-1]};
			if (!neg_q[a]) begin
				sat[a] = (dvd_q[a] > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: dvd_q[a][31:0];
			end else begin
				sat[a] = (dvd_q[a] > DVD_W'(32'h8000_0000)) ? 32'h8000_0000
					: (32'd0 - dvd_q[a][31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_query) begin
			now_q <= stamp;
			idx_q <= SLOT_W'(filled_q - FILL_W'(1));
		end else if (ctl.step) begin
			idx_q <= idx_q - SLOT_W'(1);
		end
		if (ctl.cap_new) begin
			new_x_q <= rd_x;
			new_y_q <= rd_y;
		end
		if (ctl.div_init) begin
			span_q <= age;
			for (int a = 0; a < 2; a++) begin
				neg_q[a] <= delta[a][DELTA_W-1];
				dvd_q[a] <= {(delta[a][DELTA_W-1] ? -delta[a] : delta[a]),
					{FRAC_BITS{1'b0}}};
				rem_q[a] <= '0;
			end
		end else if (ctl.div_step) begin
			for (int a = 0; a < 2; a++) begin
				if (trial[a] >= DVD_W'(span_q)) begin
					rem_q[a] <= trial[a] - DVD_W'(span_q);
					dvd_q[a] <= {dvd_q[a][DVD_W-2:0], 1'b1};
				end else begin
					rem_q[a] <= trial[a];
					dvd_q[a] <= {dvd_q[a][DVD_W-2:0], 1'b0};
				end
			end
		end
		if (ctl.out_div) begin
			vel_x_q <= $signed(sat[0]);
			vel_y_q <= $signed(sat[1]);
		end else if (ctl.out_zero) begin
			vel_x_q <= '0;
			vel_y_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.div_init) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctl.out_div || ctl.out_zero) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
endmodule
`default_nettype wire

// ----- src/touch_velocity_estimator.sv -----
// Top level of the touch velocity estimator: register port, controller, datapath.
// Record, clear and no-op words are accepted while idle. A query is accepted, then
// walks back one stored sample at a time from the newest sample (up to 16), runs
// the two bit-serial dividers (one per axis, run side by side) and loads the result
// register once it is free. With fewer than two samples stored, or when the velocity
// is forced to zero at the newest sample, the walk and division are skipped. The
// result register lets the next word be accepted while a velocity waits.
`default_nettype none
module touch_velocity_estimator import tve_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [31:0]        stamp,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y
);
	logic [15:0] stop_time_q, window_time_q;
	tve_ctl_t ctl;
	tve_sts_t sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'd0, window_time_q} : {16'd0, stop_time_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_time_q   <= STOP_RST;
			window_time_q <= WINDOW_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				window_time_q <= pwdata[15:0];
			end else begin
				stop_time_q <= pwdata[15:0];
			end
		end
	end

	tve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.ctl      (ctl),
		.in_stall (in_stall)
	);

	tve_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.stamp       (stamp),
		.stop_time   (stop_time_q),
		.window_time (window_time_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.vel_x       (vel_x),
		.vel_y       (vel_y)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_div || ctl.out_zero) |-> !(out_valid && out_stall))
		else $error("result loaded over an unread word");
	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_init |-> sts.age_pos)
		else $error("division started with non-positive span");
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr || ctl.clr || ctl.ld_query) |-> !in_stall)
		else $error("ring update while busy");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_init |=> !sts.div_done)
		else $error("divider counter not loaded");
endmodule
`default_nettype wire

// ----- dv/touch_velocity_estimator_test.sv -----
// Testbench for the touch velocity estimator: random words, predicted velocities, field checks.
`default_nettype none
module touch_velocity_estimator_test import tve_pkg::*; ;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [31:0]        st;
	} word_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} vel_t;

	localparam logic [2:0] ADDR_STOP   = 3'd0;
	localparam logic [2:0] ADDR_WINDOW = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = CMD_NOP;
	logic signed [15:0] pos_x = '0, pos_y = '0;
	logic [31:0] stamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] vel_x, vel_y;

	touch_velocity_estimator u_top (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .command, .pos_x, .pos_y, .stamp,
		.out_valid, .out_stall, .vel_x, .vel_y
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	word_t pending_words[$];
	vel_t  expected_vels[$];
	int errors = 0;
	int cycles = 0;
	int hold_cycles = 0;
	logic hold_req = 1'b0;
	int in_gap = 0, out_gap = 0;

	logic signed [15:0] mx[RING_DEPTH];
	logic signed [15:0] my[RING_DEPTH];
	logic [31:0] mst[RING_DEPTH];
	int m_slot = 0, m_fill = 0;
	logic [15:0] m_stop = STOP_RST, m_window = WINDOW_RST;

	function automatic logic signed [31:0] scaled_quot(int delta, longint span);
		longint mag, q;
		mag = (delta < 0) ? -longint'(delta) : longint'(delta);
		q = (mag <<< FRAC_BITS) / span;
		if (delta >= 0) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		if (q > 64'h80000000) q = 64'h80000000;
		return 32'(-q);
	endfunction

	function automatic int slot_at(int k);
		return (m_slot + RING_DEPTH - m_fill + k) % RING_DEPTH;
	endfunction

	task automatic predict_word(word_t w);
		vel_t v;
		int nw, i, rf;
		longint span;
		case (w.cmd)
			CMD_REC: begin
				mx[m_slot] = w.px; my[m_slot] = w.py; mst[m_slot] = w.st;
				m_slot = (m_slot + 1) % RING_DEPTH;
				if (m_fill < RING_DEPTH) m_fill++;
			end
			CMD_CLEAR: begin
				m_fill = 0; m_slot = 0;
			end
			CMD_QUERY: begin
				v = '0;
				if (m_fill >= 2) begin
					nw = slot_at(m_fill - 1);
					if (longint'($signed(w.st - mst[nw])) < longint'(m_stop)) begin
						span = 0; i = m_fill;
						while (span < longint'(m_window) && i > 0) begin
							i--;
							span = longint'($signed(w.st - mst[slot_at(i)]));
						end
						if (span > 0) begin
							rf = slot_at(i);
							v.vx = scaled_quot(int'(mx[nw]) - int'(mx[rf]), span);
							v.vy = scaled_quot(int'(my[nw]) - int'(my[rf]), span);
						end
					end
				end
				expected_vels.push_back(v);
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] exp);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, exp);
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && !in_stall) begin
			predict_word({command, pos_x, pos_y, stamp});
		end
		if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_words.size() > 0) begin
				word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				command <= w.cmd; pos_x <= w.px; pos_y <= w.py; stamp <= w.st;
				in_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_vels.size() == 0) begin
				report("unexpected", vel_x, 0);
			end else begin
				vel_t e;
				e = expected_vels.pop_front();
				if (vel_x !== e.vx) report("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report("vel_y", vel_y, e.vy);
			end
		end
		if (hold_req && hold_cycles == 0) hold_cycles <= 400;
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (out_gap > 0) begin
			out_stall <= 1'b1;
			out_gap <= out_gap - 1;
		end else begin
			out_stall <= 1'b0;
			out_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (a == ADDR_STOP) m_stop = d[15:0];
		else m_window = d[15:0];
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_vels.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic word_t mk(logic [1:0] c, int x, int y, logic [31:0] s);
		word_t w;
		w.cmd = c; w.px = 16'(x); w.py = 16'(y); w.st = s;
		return w;
	endfunction

	task automatic random_phase(int n);
		logic [31:0] t;
		int r;
		t = $urandom;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				t += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
				pending_words.push_back(mk(CMD_REC, $urandom, $urandom,
					($urandom_range(0, 19) == 0) ? $urandom : t));
			end else if (r < 92) begin
				pending_words.push_back(mk(CMD_QUERY, $urandom, $urandom,
					($urandom_range(0, 9) == 0) ? $urandom : t + $urandom_range(0, 120)));
			end else if (r < 96) begin
				pending_words.push_back(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
			end else begin
				pending_words.push_back(mk(CMD_NOP, $urandom, $urandom, $urandom));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 0));
		pending_words.push_back(mk(CMD_REC, 32767, -32768, 32'd0));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd5));
		pending_words.push_back(mk(CMD_REC, -32768, 32767, 32'd1));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd1));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd2));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd0));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd500));
		pending_words.push_back(mk(CMD_NOP, -1, -1, 32'hFFFFFFFF));
		pending_words.push_back(mk(CMD_REC, 100, -100, 32'hFFFFFFF0));
		pending_words.push_back(mk(CMD_REC, 200, -300, 32'h00000010));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'h00000020));
		pending_words.push_back(mk(CMD_CLEAR, 0, 0, 0));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'h00000020));
		for (int k = 0; k < 20; k++)
			pending_words.push_back(mk(CMD_REC, k * 1000, -k * 900, k * 5));
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd96));
		drain();
		reg_write(ADDR_WINDOW, 32'd0);
		pending_words.push_back(mk(CMD_QUERY, 0, 0, 32'd96));
		drain();
		reg_write(ADDR_STOP, 32'd65535);
		reg_write(ADDR_WINDOW, 32'd65535);
		random_phase(300);
		drain();
		reg_write(ADDR_STOP, 32'd0);
		random_phase(100);
		drain();
		reg_write(ADDR_STOP, 32'd200);
		reg_write(ADDR_WINDOW, 32'd20);
		hold_req <= 1'b1;
		random_phase(450);
		@(posedge clk);
		hold_req <= 1'b0;
		drain();
		reg_write(ADDR_STOP, 32'(STOP_RST));
		reg_write(ADDR_WINDOW, 32'(WINDOW_RST));
		random_phase(450);
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
